// File: design/lbs_pkg.sv
// Shared types, constants and helpers for the linear blend skinning core.
// Used by lbs_bank, lbs_lane and linear_blend_vertex_skinning_core.
`timescale 1ns / 1ps
package lbs_pkg;

    localparam int MAX_BONES_DEF  = 64;
    localparam int INFLUENCES_DEF = 4;
    localparam int FIELD_INF      = 4;
    localparam int WORDS_PER_BONE = 12;
    localparam int TERM_W         = 51;
    localparam int TSUM_W         = 50;

    localparam logic FUNC_SKIN = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // One bone matrix, word (row * 4 + column) at index row * 4 + column.
    typedef logic [WORDS_PER_BONE-1:0][31:0] row_t;

    // Pipeline control handed to every lane and bank.
    typedef struct packed {
        logic adv;
        logic wr_en;
    } ctl_t;

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [TERM_W+2:0] v);
        logic [31:0] r;
        if (v > (TERM_W+3)'(signed'(32'sh7FFF_FFFF)))
            r = 32'h7FFF_FFFF;
        else if (v < (TERM_W+3)'(signed'(32'sh8000_0000)))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: design/lbs_bank.sv
// One copy of the bone palette, serving a single influence lane.
// Depends on lbs_pkg for the row type and control struct.
`timescale 1ns / 1ps
module lbs_bank #(
    parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF,
    parameter int ADDR_W    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1
) (
    input  logic                clk,
    input  lbs_pkg::ctl_t       ctl,
    input  logic [ADDR_W-1:0]   waddr,
    input  logic [3:0]          wentry,
    input  logic [31:0]         wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output lbs_pkg::row_t       rdata
);

    // One row per bone, written a word at a time.
    lbs_pkg::row_t mem [MAX_BONES];

    // Word write from a load request.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr][wentry] <= wdata;
        end
    end

    // Whole-matrix read, held while the pipeline is stalled.
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/lbs_lane.sv
// One influence lane: matrix products, row sums and weighting, three stages.
// Depends on lbs_pkg for the row type, widths and control struct.
`timescale 1ns / 1ps
module lbs_lane (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lbs_pkg::ctl_t                      ctl,
    input  lbs_pkg::row_t                      mat,
    input  logic signed [31:0]                 px,
    input  logic signed [31:0]                 py,
    input  logic signed [31:0]                 pz,
    input  logic                               en,
    input  logic [15:0]                        wt,
    output logic signed [lbs_pkg::TERM_W-1:0]  term [3]
);

    logic signed [63:0] prod_reg [3][3];
    logic signed [31:0] ofs_reg [3];
    logic               en2_reg, en3_reg;
    logic [15:0]        w2_reg, w3_reg;
    logic signed [lbs_pkg::TSUM_W-1:0] t_reg [3];
    logic signed [lbs_pkg::TSUM_W-1:0] t_next [3];
    logic signed [lbs_pkg::TERM_W-1:0] term_reg [3];
    logic signed [31:0] p [3];

    assign p[0] = px;
    assign p[1] = py;
    assign p[2] = pz;

    // Stage two: nine matrix-by-position products.
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= signed'(mat[r*4+c]) * p[c];
                end
                ofs_reg[r] <= signed'(mat[r*4+3]);
            end
            w2_reg <= wt;
        end
    end

    // Row sums with the Q16.16 products floored back to 16 fraction bits.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            t_next[r] = lbs_pkg::TSUM_W'(ofs_reg[r]);
            for (int c = 0; c < 3; c++)
            begin
                t_next[r] = t_next[r] + lbs_pkg::TSUM_W'(prod_reg[r][c] >>> 16);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            t_reg  <= t_next;
            w3_reg <= w2_reg;
        end
    end

    // Stage four: weight the transformed point, floored to Q16.16.
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (en3_reg)
                begin
                    term_reg[r] <= lbs_pkg::TERM_W'(
                        (67'(t_reg[r]) * signed'({1'b0, w3_reg})) >>> 15);
                end
                else
                begin
                    term_reg[r] <= '0;
                end
            end
        end
    end

    // Lane enable travels with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en2_reg <= 1'b0;
            en3_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            en2_reg <= en;
            en3_reg <= en2_reg;
        end
    end

    assign term = term_reg;

endmodule

// File: design/linear_blend_vertex_skinning_core.sv
// Top level of the linear blend skinning core: intake, lanes, sum and output.
// Depends on lbs_pkg, lbs_bank and lbs_lane.
`timescale 1ns / 1ps
// Usage:
//   The input channel carries one request per cycle while in_stall is low (in_valid, in_stall).
//   func = 1 stores entry_value in word matrix_entry of palette slot
//   bone_slot and produces no result; func = 0 skins one vertex.
//   Joints at or above bone_count are skipped. The user must write it through
//   bone_count_we / bone_count_wdata only while the core is idle (not enforced).
//   Each influence lane owns its own copy of the palette, so all influences
//   of a vertex read their matrices in the same cycle.
//   Throughput: one request per cycle while in_stall is low.
//   A vertex is registered through the palette read at the accept edge, then
//   products, row sums, weighting, and sum with clamp, before its result
//   shows on out_valid.
//   A load is visible to a vertex accepted at the very next edge.
//   Reset clears the pipeline valid bits and bone_count; the palette is
//   undefined until written and must be loaded before use.
//   When out_stall holds a result, the whole pipeline freezes and in_stall
//   rises in the same cycle; nothing is lost or repeated.
module linear_blend_vertex_skinning_core #(
    parameter int MAX_BONES  = lbs_pkg::MAX_BONES_DEF,
    parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        bone_count_we,
    input  logic [6:0]  bone_count_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] joint_set,
    input  logic [63:0] weight_set,
    input  logic        last_vertex,
    input  logic [5:0]  bone_slot,
    input  logic [3:0]  matrix_entry,
    input  logic [31:0] entry_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic        last_out
);

    localparam int ADDR_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    logic [6:0]  bc_reg;
    logic        adv, accept;
    logic        v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic        l1_reg, l2_reg, l3_reg, l4_reg, last_out_reg;
    logic signed [31:0] px1_reg, py1_reg, pz1_reg;
    logic [8:0]  slot_ext;
    logic        wr_ok;
    lbs_pkg::ctl_t ctl;
    logic [31:0] ox_reg, oy_reg, oz_reg;
    logic signed [lbs_pkg::TERM_W-1:0] terms [INFLUENCES][3];
    logic signed [lbs_pkg::TERM_W+2:0] acc [3];

    // The whole pipeline moves unless a held result is stalled.
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;
    assign slot_ext = 9'(bone_slot);
    assign wr_ok    = accept && (func == lbs_pkg::FUNC_LOAD)
                      && (slot_ext < 9'(MAX_BONES))
                      && (matrix_entry < 4'(lbs_pkg::WORDS_PER_BONE));
    assign ctl.adv   = adv;
    assign ctl.wr_en = wr_ok;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg <= '0;
        end
        else if (bone_count_we)
        begin
            bc_reg <= bone_count_wdata;
        end
    end

    // Valid bits for each stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid && (func == lbs_pkg::FUNC_SKIN);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // Payload carried alongside the lanes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px1_reg      <= pos_x;
            py1_reg      <= pos_y;
            pz1_reg      <= pos_z;
            l1_reg       <= last_vertex;
            l2_reg       <= l1_reg;
            l3_reg       <= l2_reg;
            l4_reg       <= l3_reg;
            last_out_reg <= l4_reg;
        end
    end

    // One palette copy and one arithmetic lane per influence.
    for (genvar k = 0; k < INFLUENCES; k++)
    begin : g_inf
        logic [7:0]    jnt;
        logic [8:0]    jnt_ext;
        logic [15:0]   wgt;
        logic          use_k;
        logic          en1_reg;
        logic [15:0]   w1_reg;
        lbs_pkg::row_t row;

        if (k < lbs_pkg::FIELD_INF)
        begin : g_field
            assign jnt = joint_set[8*k +: 8];
            assign wgt = weight_set[16*k +: 16];
        end
        else
        begin : g_absent
            assign jnt = '0;
            assign wgt = '0;
        end

        assign jnt_ext = 9'(jnt);

        assign use_k = (wgt != 16'd0) && (jnt_ext < 9'(bc_reg))
                       && (jnt_ext < 9'(MAX_BONES)) && (k < lbs_pkg::FIELD_INF);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                en1_reg <= 1'b0;
            end
            else if (adv)
            begin
                en1_reg <= use_k;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                w1_reg <= wgt;
            end
        end

        lbs_bank #(
            .MAX_BONES (MAX_BONES),
            .ADDR_W    (ADDR_W)
        ) u_bank (
            .clk    (clk),
            .ctl    (ctl),
            .waddr  (slot_ext[ADDR_W-1:0]),
            .wentry (matrix_entry),
            .wdata  (entry_value),
            .raddr  (jnt_ext[ADDR_W-1:0]),
            .rdata  (row)
        );

        lbs_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .mat   (row),
            .px    (px1_reg),
            .py    (py1_reg),
            .pz    (pz1_reg),
            .en    (en1_reg),
            .wt    (w1_reg),
            .term  (terms[k])
        );
    end

    // Sum the influence terms and clamp to Q16.16.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = '0;
            for (int k = 0; k < INFLUENCES; k++)
            begin
                acc[r] = acc[r] + (lbs_pkg::TERM_W+3)'(terms[k][r]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg <= lbs_pkg::sat32(acc[0]);
            oy_reg <= lbs_pkg::sat32(acc[1]);
            oz_reg <= lbs_pkg::sat32(acc[2]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign last_out  = last_out_reg;

    // A vertex in the weighting stage reaches the output when the pipe moves.
    a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && adv) |=> out_valid_reg)
        else $error("vertex lost between weighting and output");

    // A load request never enters the vertex pipeline.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == lbs_pkg::FUNC_LOAD) |=> !v1_reg)
        else $error("load request produced a pipeline entry");

    // A new result appears only from a vertex in the previous stage.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v4_reg))
        else $error("result appeared without a vertex behind it");

endmodule
